// ===== src/bwg_pkg.sv =====
// Shared types, constants and helpers for the Blackman window generator.
// No dependencies.
package bwg_pkg;

    typedef logic signed [17:0] t_coef;

    localparam int DIV_NW = 36;
    localparam int DIV_DW = 24;

    localparam logic [1:0] CFG_LENGTH    = 2'd0;
    localparam logic [1:0] CFG_NORMALIZE = 2'd1;
    localparam logic [1:0] CFG_EXACT     = 2'd2;

    localparam logic signed [14:0] A0_EXACT = 15'sd7938;
    localparam logic signed [14:0] A1_EXACT = 15'sd9240;
    localparam logic signed [14:0] A2_EXACT = 15'sd1430;
    localparam logic [23:0] DEN_EXACT = 24'd18608;
    localparam logic signed [14:0] A0_COMMON = 15'sd42;
    localparam logic signed [14:0] A1_COMMON = 15'sd50;
    localparam logic signed [14:0] A2_COMMON = 15'sd8;
    localparam logic [23:0] DEN_COMMON = 24'd100;

    localparam logic signed [25:0] ONE_Q16 = 26'sd65536;
    localparam logic signed [25:0] SAT_HI = 26'sd131071;
    localparam logic signed [25:0] SAT_LO = -26'sd131072;

    // magnitude plus sign back to a saturated 18-bit sample
    function automatic t_coef sat_mag(input logic [DIV_NW-1:0] q, input logic neg);
        t_coef r;
        if (!neg) begin
            r = (q > DIV_NW'(131071)) ? 18'sd131071 : t_coef'(q[17:0]);
        end else begin
            r = (q > DIV_NW'(131072)) ? -18'sd131072 : t_coef'(-q[17:0]);
        end
        return r;
    endfunction

    function automatic t_coef sat_wide(input logic signed [25:0] v);
        t_coef r;
        if (v > SAT_HI) begin
            r = 18'sd131071;
        end else if (v < SAT_LO) begin
            r = -18'sd131072;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

endpackage

// ===== src/bwg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bwg_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/bwg_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bwg_pkg for operand widths.
module bwg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bwg_pkg::DIV_NW-1:0] i_num,
    input  logic [bwg_pkg::DIV_DW-1:0] i_den,
    output logic                      o_done,
    output logic [bwg_pkg::DIV_NW-1:0] o_quot
);
    localparam int NW = bwg_pkg::DIV_NW;
    localparam int DW = bwg_pkg::DIV_DW;
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_den, r_rem;
    logic [NW-1:0] r_quot;
    logic [CW-1:0] r_cnt;
    logic          r_run, r_done;
    logic [DW:0]   w_sh, w_diff;
    logic          w_ge;

    always_comb begin
        w_sh   = {r_rem, r_quot[NW-1]};
        w_ge   = w_sh >= {1'b0, r_den};
        w_diff = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
            r_cnt  <= CW'(NW);
            r_run  <= 1'b1;
            r_done <= 1'b0;
        end else if (r_run) begin
            r_rem  <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_quot <= {r_quot[NW-2:0], w_ge};
            r_cnt  <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== src/bwg_cos.sv =====
// Quarter-wave cosine table with quadrant folding, Q1.16 result.
// Table is built at elaboration from a Taylor series. Depends on bwg_pkg.
module bwg_cos #(
    parameter int DEPTH = 256
) (
    input  logic [$clog2(DEPTH)+1:0] i_angle,
    output bwg_pkg::t_coef           o_cos
);
    localparam int RW = $clog2(DEPTH);
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    function automatic logic [16:0] cos_entry(input logic [63:0] x);
        logic [63:0] term;
        logic signed [63:0] acc;
        logic signed [63:0] v;
        term = 64'd1 << 30;
        acc  = 64'sd1 <<< 30;
        for (int k = 1; k <= 10; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0) begin
            acc = '0;
        end
        v = (acc + 64'sd8192) >>> 14;
        if (v > 64'sd65536) begin
            v = 64'sd65536;
        end
        return v[16:0];
    endfunction

    logic [16:0] w_rom [DEPTH+1];

    for (genvar gi = 0; gi <= DEPTH; gi++) begin : g_rom
        localparam logic [63:0] X = (64'(gi) * PI_HALF_Q30 + 64'(DEPTH / 2)) / 64'(DEPTH);
        assign w_rom[gi] = cos_entry(X);
    end

    logic [1:0]    w_quad;
    logic [RW-1:0] w_res;
    logic [RW:0]   w_addr;
    logic [17:0]   w_mag;

    always_comb begin
        w_quad = i_angle[RW+1:RW];
        w_res  = i_angle[RW-1:0];
        w_addr = w_quad[0] ? ((RW+1)'(DEPTH) - {1'b0, w_res}) : {1'b0, w_res};
        w_mag  = {1'b0, w_rom[w_addr]};
        o_cos  = (w_quad == 2'd1 || w_quad == 2'd2) ? -$signed(w_mag) : $signed(w_mag);
    end
endmodule

// ===== src/blackman_window_generator.sv =====
// Blackman window generator: sequencer around a shared divider and multiplier.
// Depends on bwg_pkg, bwg_div, bwg_cos, bwg_ram.
//
// Usage: write window_length (index 0), normalize_enable (1) and
// exact_coefficients (2) on the cfg channel while the block is idle; cfg is
// always ready. Pulse i_start with i_start_request high while o_busy is low.
// The block then streams L samples (length capped at MAX_POINTS) on o_valid,
// one per cycle, sample_index 0..L-1, o_last_sample on the final one. A
// length below two gives a single result with o_length_error set, in the next cycle.
// Sequence: each sample needs three passes of the shared divider
// (two angles and the coefficient divide) plus the sequencing states;
// normalization adds up to one more divider pass per point. The stream
// starts once the last point is stored (after the midpoint correction with
// normalization), then runs at one sample per cycle. o_busy stays high
// until the last sample is on the result ports.
// Reset clears the sequencer and restores the register defaults; the sample
// store needs no clearing. Results cannot be stalled by the receiver.
module blackman_window_generator #(
    parameter int MAX_POINTS = 64,
    parameter int COSINE_TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_start_request,
    output logic        o_busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    output logic        o_valid,
    output logic signed [17:0] o_coefficient,
    output logic [5:0]  o_sample_index,
    output logic        o_last_sample,
    output logic        o_length_error
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int FW = $clog2(COSINE_TABLE_DEPTH) + 2;
    localparam int NW = bwg_pkg::DIV_NW;
    localparam int DW = bwg_pkg::DIV_DW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AGO   = 4'd1;
    localparam logic [3:0] S_AWAIT = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_MUL2  = 4'd4;
    localparam logic [3:0] S_WGO   = 4'd5;
    localparam logic [3:0] S_WWAIT = 4'd6;
    localparam logic [3:0] S_NRD   = 4'd7;
    localparam logic [3:0] S_NGO   = 4'd8;
    localparam logic [3:0] S_NWAIT = 4'd9;
    localparam logic [3:0] S_MRD   = 4'd10;
    localparam logic [3:0] S_MWR   = 4'd11;
    localparam logic [3:0] S_ERD   = 4'd12;
    localparam logic [3:0] S_EMIT  = 4'd13;

    logic [3:0] r_state, n_state;
    logic [6:0] r_wl, r_len, n_len, r_cnt, n_cnt;
    logic       r_norm, r_exact, r_k, n_k, r_neg, n_neg;
    bwg_pkg::t_coef r_c1, n_c1, r_c2, n_c2;
    logic signed [32:0] r_acc, n_acc;
    logic signed [23:0] r_sum, n_sum, r_nsum, n_nsum;
    logic       r_valid, n_valid, r_last, n_last, r_err, n_err;
    bwg_pkg::t_coef r_coef, n_coef;
    logic [5:0] r_idx, n_idx;

    logic          w_div_start, w_div_done;
    logic [NW-1:0] w_div_num, w_div_quot;
    logic [DW-1:0] w_div_den;
    bwg_pkg::t_coef w_cos, w_rdata, w_wdata, w_qsat;
    logic [17:0]   w_rraw;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [6:0]    w_cnt_inc, w_p, w_mid;
    logic signed [14:0] w_a0, w_a1, w_a2, w_ma;
    bwg_pkg::t_coef w_mb;
    logic [DW-1:0] w_den;
    logic signed [31:0] w_prod;
    logic signed [32:0] w_abs_acc;
    logic [17:0]   w_abs_w;
    logic          w_accept;

    bwg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    bwg_cos #(.DEPTH(COSINE_TABLE_DEPTH)) u_cos (
        .i_angle (w_div_quot[FW-1:0]),
        .o_cos   (w_cos)
    );

    bwg_ram #(.WIDTH(18), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rraw)
    );

    assign w_rdata  = $signed(w_rraw);
    assign w_accept = i_start && (r_state == S_IDLE) && i_start_request;

    always_comb begin
        w_a0  = r_exact ? bwg_pkg::A0_EXACT  : bwg_pkg::A0_COMMON;
        w_a1  = r_exact ? bwg_pkg::A1_EXACT  : bwg_pkg::A1_COMMON;
        w_a2  = r_exact ? bwg_pkg::A2_EXACT  : bwg_pkg::A2_COMMON;
        w_den = r_exact ? bwg_pkg::DEN_EXACT : bwg_pkg::DEN_COMMON;
        w_ma  = (r_state == S_MUL1) ? w_a1 : w_a2;
        w_mb  = (r_state == S_MUL1) ? r_c1 : r_c2;
        w_prod = w_ma * w_mb;
        w_p    = r_len - 7'd1;
        w_mid  = r_len >> 1;
        w_cnt_inc = r_cnt + 7'd1;
        w_abs_acc = (r_acc < 0) ? -r_acc : r_acc;
        w_abs_w   = (w_rdata < 0) ? 18'(-w_rdata) : 18'(w_rdata);
        w_qsat    = bwg_pkg::sat_mag(w_div_quot, r_neg);
    end

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_neg   = r_neg;
        n_c1    = r_c1;
        n_c2    = r_c2;
        n_acc   = r_acc;
        n_sum   = r_sum;
        n_nsum  = r_nsum;
        n_valid = 1'b0;
        n_last  = r_last;
        n_err   = r_err;
        n_coef  = r_coef;
        n_idx   = r_idx;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = w_den;
        w_we    = 1'b0;
        w_waddr = r_cnt[AW-1:0];
        w_wdata = w_qsat;
        w_raddr = r_cnt[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_wl < 7'd2) begin
                        n_valid = 1'b1;
                        n_coef  = '0;
                        n_idx   = '0;
                        n_last  = 1'b1;
                        n_err   = 1'b1;
                    end else begin
                        n_len   = (r_wl > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : r_wl;
                        n_cnt   = '0;
                        n_k     = 1'b0;
                        n_sum   = '0;
                        n_state = S_AGO;
                    end
                end
            end
            S_AGO: begin
                w_div_start = 1'b1;
                w_div_num   = (NW'(r_cnt) << (FW + 1 + 32'(r_k))) + NW'(w_p);
                w_div_den   = DW'({w_p, 1'b0});
                n_state     = S_AWAIT;
            end
            S_AWAIT: begin
                if (w_div_done) begin
                    if (!r_k) begin
                        n_c1    = w_cos;
                        n_k     = 1'b1;
                        n_state = S_AGO;
                    end else begin
                        n_c2    = w_cos;
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                n_acc   = (33'(w_a0) <<< 16) - 33'(w_prod);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_acc   = r_acc + 33'(w_prod);
                n_state = S_WGO;
            end
            S_WGO: begin
                w_div_start = 1'b1;
                w_div_num   = NW'(w_abs_acc) + NW'(w_den >> 1);
                n_neg       = r_acc < 0;
                n_state     = S_WWAIT;
            end
            S_WWAIT: begin
                if (w_div_done) begin
                    w_we  = 1'b1;
                    n_sum = r_sum + 24'(w_qsat);
                    if (w_cnt_inc == r_len) begin
                        n_cnt   = '0;
                        n_nsum  = '0;
                        n_state = r_norm ? S_NRD : S_ERD;
                    end else begin
                        n_cnt   = w_cnt_inc;
                        n_k     = 1'b0;
                        n_state = S_AGO;
                    end
                end
            end
            S_NRD: begin
                n_state = S_NGO;
            end
            S_NGO: begin
                if (r_sum <= 0) begin
                    w_we    = 1'b1;
                    w_wdata = '0;
                    if (w_cnt_inc == r_len) begin
                        n_state = S_MRD;
                    end else begin
                        n_cnt   = w_cnt_inc;
                        n_state = S_NRD;
                    end
                end else begin
                    w_div_start = 1'b1;
                    w_div_num   = (NW'(w_abs_w) << 16) + NW'(r_sum >>> 1);
                    w_div_den   = DW'(r_sum);
                    n_neg       = w_rdata < 0;
                    n_state     = S_NWAIT;
                end
            end
            S_NWAIT: begin
                w_div_den = DW'(r_sum);
                if (w_div_done) begin
                    w_we   = 1'b1;
                    n_nsum = r_nsum + 24'(w_qsat);
                    if (w_cnt_inc == r_len) begin
                        n_state = S_MRD;
                    end else begin
                        n_cnt   = w_cnt_inc;
                        n_state = S_NRD;
                    end
                end
            end
            S_MRD: begin
                w_raddr = w_mid[AW-1:0];
                n_state = S_MWR;
            end
            S_MWR: begin
                w_we    = 1'b1;
                w_waddr = w_mid[AW-1:0];
                w_wdata = bwg_pkg::sat_wide(26'(w_rdata) + bwg_pkg::ONE_Q16 - 26'(r_nsum));
                n_cnt   = '0;
                n_state = S_ERD;
            end
            S_ERD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                w_raddr = w_cnt_inc[AW-1:0];
                n_valid = 1'b1;
                n_coef  = w_rdata;
                n_idx   = 6'(r_cnt);
                n_last  = w_cnt_inc == r_len;
                n_err   = 1'b0;
                n_cnt   = w_cnt_inc;
                if (w_cnt_inc == r_len) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wl    <= 7'd64;
            r_norm  <= 1'b0;
            r_exact <= 1'b0;
            r_valid <= 1'b0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_k     <= 1'b0;
            r_sum   <= '0;
            r_nsum  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_sum   <= n_sum;
            r_nsum  <= n_nsum;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bwg_pkg::CFG_LENGTH:    r_wl    <= i_cfg_data;
                    bwg_pkg::CFG_NORMALIZE: r_norm  <= i_cfg_data[0];
                    bwg_pkg::CFG_EXACT:     r_exact <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_c1   <= n_c1;
        r_c2   <= n_c2;
        r_acc  <= n_acc;
        r_last <= n_last;
        r_err  <= n_err;
        r_coef <= n_coef;
        r_idx  <= n_idx;
    end

    assign o_busy         = r_state != S_IDLE;
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_valid;
    assign o_coefficient  = r_coef;
    assign o_sample_index = r_idx;
    assign o_last_sample  = r_last;
    assign o_length_error = r_err;

`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_length_error |-> o_last_sample)
        else $error("length error result not marked last");
    a_stream_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_sample |=> o_valid)
        else $error("sample stream has a gap");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_AWAIT || r_state == S_WWAIT || r_state == S_NWAIT))
        else $error("divider finished outside a wait state");
`endif
endmodule

// ===== tb/sv/blackman_window_generator_tb.sv =====
// Self-checking testbench for blackman_window_generator: queued config writes and start
// items, an in-bench window predictor, and a monitor comparing every streamed sample.
// Depends on bwg_pkg and the blackman_window_generator RTL.
module blackman_window_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_LIMIT = 40000;
    localparam int RANDOM_STARTS = 320;

    typedef struct {
        bit         is_cfg;
        logic [1:0] index;
        logic [6:0] data;
        bit         request;
    } t_item;

    typedef struct {
        bwg_pkg::t_coef coef;
        logic [5:0] index;
        logic       last;
        logic       error;
    } t_sample;

    logic i_clk, i_rst_n, i_start, i_start_request, o_busy;
    logic i_cfg_valid, o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [6:0] i_cfg_data;
    logic o_valid, o_last_sample, o_length_error;
    logic signed [17:0] o_coefficient;
    logic [5:0] o_sample_index;

    t_item   pending_items[$];
    t_sample expected_samples[$];
    int      cos_quarter[0:256];
    int      length_reg;
    bit      normalize_reg, exact_reg;
    int      gap_cycles, settle_cycles, idle_cycles, tail_items;
    bit      failed;

    blackman_window_generator dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void build_cos_quarter();
        longint unsigned x, term;
        longint s, v;
        for (int i = 0; i <= 256; i++) begin
            x = (longint'(i) * 64'd1686629713 + 128) / 256;
            term = 64'd1 << 30;
            s = 64'sd1 << 30;
            for (int k = 1; k <= 10; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / ((2 * k - 1) * (2 * k));
                if (k % 2 == 1) s = s - longint'(term);
                else s = s + longint'(term);
            end
            if (s < 0) s = 0;
            v = (s + 8192) >>> 14;
            if (v > 65536) v = 65536;
            cos_quarter[i] = int'(v);
        end
    endfunction

    function automatic longint cos_at(longint unsigned a);
        int unsigned q, r;
        a = a % 1024;
        q = 32'(a / 256);
        r = 32'(a % 256);
        case (q)
            0: return cos_quarter[r];
            1: return -cos_quarter[256 - r];
            2: return -cos_quarter[r];
            default: return cos_quarter[256 - r];
        endcase
    endfunction

    function automatic longint div_round(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint clip18(longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    function automatic void predict_window();
        longint w[64];
        longint a0, a1, a2, den, total, nsum;
        longint unsigned num, span, ang1, ang2;
        int len;
        t_sample s;
        len = length_reg;
        if (len < 2) begin
            s.coef = '0; s.index = '0; s.last = 1'b1; s.error = 1'b1;
            expected_samples.push_back(s);
            return;
        end
        if (len > 64) len = 64;
        if (exact_reg) begin
            a0 = 7938; a1 = 9240; a2 = 1430; den = 18608;
        end else begin
            a0 = 42; a1 = 50; a2 = 8; den = 100;
        end
        span = len - 1;
        total = 0;
        for (int l = 0; l < len; l++) begin
            num = longint'(l) * 1024;
            ang1 = (2 * num + span) / (2 * span);
            ang2 = (4 * num + span) / (2 * span);
            w[l] = clip18(div_round(a0 * 65536 - a1 * cos_at(ang1) + a2 * cos_at(ang2), den));
            total += w[l];
        end
        if (normalize_reg) begin
            nsum = 0;
            for (int l = 0; l < len; l++) begin
                w[l] = (total > 0) ? clip18(div_round(w[l] * 65536, total)) : 0;
                nsum += w[l];
            end
            w[len / 2] = clip18(w[len / 2] + 65536 - nsum);
        end
        for (int l = 0; l < len; l++) begin
            s.coef = bwg_pkg::t_coef'(w[l]);
            s.index = 6'(l);
            s.last = (l == len - 1);
            s.error = 1'b0;
            expected_samples.push_back(s);
        end
    endfunction

    task automatic queue_cfg(logic [1:0] index, logic [6:0] data);
        t_item it;
        it.is_cfg = 1'b1; it.index = index; it.data = data; it.request = 1'b0;
        pending_items.push_back(it);
    endtask

    task automatic queue_start(bit request);
        t_item it;
        it.is_cfg = 1'b0; it.index = '0; it.data = '0; it.request = request;
        pending_items.push_back(it);
    endtask

    // driver and predictor share one clocked block so acceptance and queueing stay in order
    always @(posedge i_clk) begin
        logic nxt_start, nxt_request, nxt_cfg_valid;
        logic [1:0] nxt_index;
        logic [6:0] nxt_data;
        t_item it;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_start_request <= 1'b0;
            i_cfg_valid <= 1'b0;
            i_cfg_index <= bwg_pkg::CFG_LENGTH;
            i_cfg_data <= '0;
            length_reg = 64; normalize_reg = 1'b0; exact_reg = 1'b0;
            gap_cycles = 0; settle_cycles = SETTLE_CYCLES;
        end else begin
            nxt_start = i_start; nxt_request = i_start_request;
            nxt_cfg_valid = i_cfg_valid; nxt_index = i_cfg_index; nxt_data = i_cfg_data;
            if (i_start && !o_busy) begin
                if (i_start_request) predict_window();
                nxt_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bwg_pkg::CFG_LENGTH: length_reg = i_cfg_data;
                    bwg_pkg::CFG_NORMALIZE: normalize_reg = i_cfg_data[0];
                    bwg_pkg::CFG_EXACT: exact_reg = i_cfg_data[0];
                    default: ;
                endcase
                nxt_cfg_valid = 1'b0;
            end
            if (expected_samples.size() != 0 || o_busy || nxt_start) settle_cycles = SETTLE_CYCLES;
            else if (settle_cycles > 0) settle_cycles--;
            if (!nxt_start && !nxt_cfg_valid) begin
                if (gap_cycles > 0) begin
                    gap_cycles--;
                end else if (pending_items.size() != 0) begin
                    it = pending_items[0];
                    if (!it.is_cfg) begin
                        void'(pending_items.pop_front());
                        nxt_start = 1'b1; nxt_request = it.request;
                    end else if (settle_cycles == 0) begin
                        void'(pending_items.pop_front());
                        nxt_cfg_valid = 1'b1; nxt_index = it.index; nxt_data = it.data;
                    end
                    if (pending_items.size() > tail_items && $urandom_range(0, 3) == 0)
                        gap_cycles = $urandom_range(1, 5);
                end
            end
            i_start <= nxt_start;
            i_start_request <= nxt_request;
            i_cfg_valid <= nxt_cfg_valid;
            i_cfg_index <= nxt_index;
            i_cfg_data <= nxt_data;
        end
    end

    always @(posedge i_clk) begin
        t_sample s;
        if (i_rst_n && o_valid) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample: expected none, actual coef %0d index %0d",
                         $realtime, o_coefficient, o_sample_index);
                failed = 1'b1;
            end else begin
                s = expected_samples.pop_front();
                if (o_coefficient !== s.coef) begin
                    $display("%0t: coefficient[%0d]: expected %0d, actual %0d",
                             $realtime, s.index, s.coef, o_coefficient);
                    failed = 1'b1;
                end
                if (o_sample_index !== s.index) begin
                    $display("%0t: sample_index: expected %0d, actual %0d",
                             $realtime, s.index, o_sample_index);
                    failed = 1'b1;
                end
                if (o_last_sample !== s.last) begin
                    $display("%0t: last_sample[%0d]: expected %0b, actual %0b",
                             $realtime, s.index, s.last, o_last_sample);
                    failed = 1'b1;
                end
                if (o_length_error !== s.error) begin
                    $display("%0t: length_error[%0d]: expected %0b, actual %0b",
                             $realtime, s.index, s.error, o_length_error);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || (i_cfg_valid && o_cfg_ready) || o_valid) begin
            idle_cycles = 0;
        end else if (++idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d samples outstanding", $realtime,
                     expected_samples.size());
            $display("blackman_window_generator verification failed");
            $finish;
        end
    end

    initial begin
        int starts, burst, r, len;
        failed = 1'b0;
        idle_cycles = 0;
        tail_items = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0; i_start_request = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = bwg_pkg::CFG_LENGTH; i_cfg_data = '0;
        build_cos_quarter();

        queue_start(1'b1);
        queue_start(1'b0);
        queue_cfg(bwg_pkg::CFG_EXACT, 7'd1);
        queue_start(1'b1);
        queue_cfg(bwg_pkg::CFG_NORMALIZE, 7'd1);
        queue_start(1'b1);
        queue_cfg(bwg_pkg::CFG_EXACT, 7'd0);
        queue_start(1'b1);
        queue_cfg(bwg_pkg::CFG_LENGTH, 7'd0);   queue_start(1'b1);
        queue_cfg(bwg_pkg::CFG_LENGTH, 7'd1);   queue_start(1'b1);
        queue_cfg(bwg_pkg::CFG_LENGTH, 7'd2);   queue_start(1'b1);
        queue_cfg(bwg_pkg::CFG_LENGTH, 7'd3);   queue_start(1'b1);
        queue_cfg(bwg_pkg::CFG_LENGTH, 7'd127); queue_start(1'b1);
        queue_cfg(bwg_pkg::CFG_LENGTH, 7'd65);  queue_start(1'b0); queue_start(1'b1);
        queue_cfg(bwg_pkg::CFG_EXACT, 7'd1);
        queue_cfg(bwg_pkg::CFG_LENGTH, 7'd2);   queue_start(1'b1);

        starts = 0;
        while (starts < RANDOM_STARTS) begin
            r = $urandom_range(0, 99);
            if (r < 8) len = $urandom_range(0, 1);
            else if (r < 85) len = $urandom_range(2, 12);
            else if (r < 95) len = $urandom_range(13, 64);
            else len = $urandom_range(65, 127);
            queue_cfg(bwg_pkg::CFG_NORMALIZE, 7'($urandom_range(0, 1)));
            queue_cfg(bwg_pkg::CFG_LENGTH, 7'(len));
            queue_cfg(bwg_pkg::CFG_EXACT, 7'($urandom_range(0, 1)));
            burst = (len > 12) ? $urandom_range(1, 3) : $urandom_range(5, 20);
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    queue_start(1'b0);
                end else begin
                    queue_start(1'b1);
                    starts++;
                end
            end
        end
        tail_items = 30;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_items.size() != 0 || i_start || i_cfg_valid ||
               expected_samples.size() != 0);
        repeat (50) @(posedge i_clk);
        if (!failed && expected_samples.size() == 0) begin
            $display("blackman_window_generator verification clean");
        end else begin
            $display("blackman_window_generator verification failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/bwg_pkg.sv
src/bwg_ram.sv
src/bwg_div.sv
src/bwg_cos.sv
src/blackman_window_generator.sv
tb/sv/blackman_window_generator_tb.sv
